/* src/pnpc_pkg.sv */
// ----------------------------------------------------------------------------
// pnpc_pkg
// Shared constants, codes and types of the gradient noise pixel colour block.
// ----------------------------------------------------------------------------
package pnpc_pkg;

	// grid and number formats
	localparam int GRID_DIM       = 64;
	localparam int GRID_BITS      = $clog2(GRID_DIM);
	localparam int COORD_BITS     = 12;
	localparam int GRAD_FRAC_BITS = 14;
	localparam int GRAD_BITS      = 16;
	localparam int SIZE_BITS      = 10;
	localparam int MODE_BITS      = 2;
	localparam int CFG_INDEX_BITS = 2;
	localparam int T_BITS         = 16;
	localparam int FADE_BITS      = T_BITS + 1;
	localparam int NOISE_BITS     = 20;
	localparam int COLOUR_BITS    = 8;

	// gradient table split into four banks by column and row parity
	localparam int NUM_BANKS      = 4;
	localparam int BANK_DEPTH     = GRID_DIM * GRID_DIM / NUM_BANKS;
	localparam int BANK_ADDR_BITS = $clog2(BANK_DEPTH);
	localparam int ENTRY_BITS     = 2 * GRAD_BITS;

	// register reset values
	localparam int CELL_RESET = 16;
	localparam int MODE_RESET = 0;

	// quintic fade 6t^2 - 15t + 10
	localparam int FADE_A = 6;
	localparam int FADE_B = 15;
	localparam int FADE_C = 10;

	// colour map
	localparam int VALUE_OFFSET  = 40;
	localparam int RAMP_SCALE    = 3;
	localparam int STRIPE_PERIOD = 6;
	localparam int RECIP_SHIFT   = 16;
	localparam int RECIP6        = ((1 << RECIP_SHIFT) + STRIPE_PERIOD - 1) / STRIPE_PERIOD;
	localparam int STRIPE_A      = 0;
	localparam int STRIPE_B      = 2;
	localparam int STRIPE_C      = 4;
	localparam int COL_100       = 100;
	localparam int COL_150       = 150;
	localparam int COL_200       = 200;
	localparam int COL_20        = 20;
	localparam int COL_250       = 250;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_PIXEL = 1'b1
	} op_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_CELL_WIDTH  = 2'd0,
		CFG_CELL_HEIGHT = 2'd1,
		CFG_COLOUR_MODE = 2'd2
	} cfg_index_t;

	typedef enum logic [MODE_BITS-1:0] {
		MODE_RAMP    = 2'd0,
		MODE_STRIPES = 2'd1,
		MODE_BLACK   = 2'd2
	} mode_t;

	// one coordinate on its way through the divider stages
	typedef struct packed {
		logic [COORD_BITS-1:0] num;
		logic [COORD_BITS-1:0] quo;
		logic [SIZE_BITS-1:0]  rem;
		logic [SIZE_BITS-1:0]  off;
		logic [T_BITS-1:0]     frac;
	} lane_t;

	// item kind and gradient write word riding along the divider stages
	typedef struct packed {
		op_t                         op;
		logic [GRID_BITS-1:0]        col;
		logic [GRID_BITS-1:0]        row;
		logic signed [GRAD_BITS-1:0] gx;
		logic signed [GRAD_BITS-1:0] gy;
	} ctl_t;

endpackage

/* src/pnpc_ram.sv */
// ----------------------------------------------------------------------------
// pnpc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module pnpc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* src/pnpc_fade.sv */
// ----------------------------------------------------------------------------
// pnpc_fade
// Four stage quintic fade weight t^3 (6t^2 - 15t + 10) in Q1.16.
// ----------------------------------------------------------------------------
module pnpc_fade import pnpc_pkg::*; (
	input  logic                 clk,
	input  logic [T_BITS-1:0]    t,
	output logic [FADE_BITS-1:0] fade
);

	localparam int QSUM_BITS = 2 * T_BITS + 6;
	localparam int Q_BITS    = T_BITS + 4;

	logic [T_BITS-1:0]    t_s1, t_s2;
	logic [2*T_BITS-1:0]  tt_s1;
	logic [Q_BITS-1:0]    q_s2, q_s3;
	logic [T_BITS-1:0]    c1_s2, c_s3;
	logic [QSUM_BITS-1:0] qsum;
	logic [2*T_BITS-1:0]  cprod;
	logic [T_BITS+Q_BITS-1:0] fprod;

	always_comb begin
		qsum = (QSUM_BITS'(FADE_C) << (2 * T_BITS))
			+ QSUM_BITS'(tt_s1) * QSUM_BITS'(FADE_A)
			- ((QSUM_BITS'(t_s1) * QSUM_BITS'(FADE_B)) << T_BITS);
		cprod = c1_s2 * t_s2;
		fprod = c_s3 * q_s3;
	end

	always_ff @(posedge clk) begin
		t_s1  <= t;
		tt_s1 <= t * t;
		t_s2  <= t_s1;
		q_s2  <= qsum[T_BITS +: Q_BITS];
		c1_s2 <= tt_s1[T_BITS +: T_BITS];
		q_s3  <= q_s2;
		c_s3  <= cprod[T_BITS +: T_BITS];
		fade  <= fprod[T_BITS +: FADE_BITS];
	end

endmodule

/* src/perlin_noise_pixel_colour_top.sv */
// ----------------------------------------------------------------------------
// perlin_noise_pixel_colour_top
// 2D gradient noise for one pixel per cycle while not busy, with colour map, over a banked
// gradient table.
// ----------------------------------------------------------------------------
// result: done goes high with the noise and colour of an accepted pixel, after
//   the input register, the 28 divider stages, the table read and the blend
// throughput: one word per cycle, pixel or gradient write, while not busy
// reset: registers to defaults, then busy while the four table banks are
//   cleared one row per cycle; config writes always taken
// ----------------------------------------------------------------------------
module perlin_noise_pixel_colour_top import pnpc_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          operation,
	input  logic [COORD_BITS-1:0]         pixel_x,
	input  logic [COORD_BITS-1:0]         pixel_y,
	input  logic [GRID_BITS-1:0]          grid_col,
	input  logic [GRID_BITS-1:0]          grid_row,
	input  logic signed [GRAD_BITS-1:0]   grad_x,
	input  logic signed [GRAD_BITS-1:0]   grad_y,
	output logic                          done,
	output logic signed [NOISE_BITS-1:0]  noise_value,
	output logic [COLOUR_BITS-1:0]        red,
	output logic [COLOUR_BITS-1:0]        green,
	output logic [COLOUR_BITS-1:0]        blue,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [SIZE_BITS-1:0]          cfg_data
);

	localparam int STAGES  = COORD_BITS + T_BITS;
	localparam int POST    = 11;
	localparam int PROD_W  = GRAD_BITS + SIZE_BITS + 1;
	localparam int VAL_W   = PROD_W + 1;
	localparam int DIF_W   = VAL_W + 1;
	localparam int MUL_W   = DIF_W + FADE_BITS + 1;
	localparam int AB_W    = DIF_W + 1;
	localparam int DB_W    = AB_W + 1;
	localparam int MUL2_W  = DB_W + FADE_BITS + 1;
	localparam int V_W     = NOISE_BITS - 8 + 2;
	localparam int ABS_W   = V_W - 1;
	localparam int RP_W    = ABS_W + RECIP_SHIFT;
	localparam int Q6_W    = RP_W - RECIP_SHIFT;

	// configuration
	logic [SIZE_BITS-1:0] cell_width_q, cell_height_q, w_eff, h_eff;
	logic [MODE_BITS-1:0] colour_mode_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_width_q  <= SIZE_BITS'(CELL_RESET);
			cell_height_q <= SIZE_BITS'(CELL_RESET);
			colour_mode_q <= MODE_BITS'(MODE_RESET);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CELL_WIDTH:  cell_width_q  <= cfg_data;
				CFG_CELL_HEIGHT: cell_height_q <= cfg_data;
				CFG_COLOUR_MODE: colour_mode_q <= cfg_data[MODE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// zero size acts as one
	assign w_eff = (cell_width_q == '0) ? SIZE_BITS'(1) : cell_width_q;
	assign h_eff = (cell_height_q == '0) ? SIZE_BITS'(1) : cell_height_q;

	// table clearing after reset
	logic                      clr_q;
	logic [BANK_ADDR_BITS-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == '1) begin
				clr_q <= 1'b0;
			end
		end
	end

	assign busy = clr_q;

	logic accept;
	assign accept = start && !busy;

	// divider stages: cell index and offset, then offset over size in Q0.16
	function automatic lane_t lane_step(input lane_t a, input logic [SIZE_BITS-1:0] d,
			input logic frac_phase);
		lane_t              r;
		logic [SIZE_BITS:0] r2;
		logic               ge;
		r  = a;
		r2 = {a.rem, frac_phase ? 1'b0 : a.num[COORD_BITS-1]};
		ge = r2 >= {1'b0, d};
		r.rem = ge ? SIZE_BITS'(r2 - {1'b0, d}) : r2[SIZE_BITS-1:0];
		if (frac_phase) begin
			r.frac = {a.frac[T_BITS-2:0], ge};
		end else begin
			r.num = a.num << 1;
			r.quo = {a.quo[COORD_BITS-2:0], ge};
			r.off = r.rem;
		end
		return r;
	endfunction

	lane_t             lane_x_s [STAGES+1];
	lane_t             lane_y_s [STAGES+1];
	ctl_t              ctl_s    [STAGES+1];
	logic [STAGES:0]   pipe_vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pipe_vld_s <= '0;
		end else begin
			pipe_vld_s <= {pipe_vld_s[STAGES-1:0], accept};
		end
	end

	always_ff @(posedge clk) begin
		lane_x_s[0] <= '{num: pixel_x, quo: '0, rem: '0, off: '0, frac: '0};
		lane_y_s[0] <= '{num: pixel_y, quo: '0, rem: '0, off: '0, frac: '0};
		ctl_s[0]    <= '{op: op_t'(operation), col: grid_col, row: grid_row,
			gx: grad_x, gy: grad_y};
	end

	for (genvar k = 0; k < STAGES; k++) begin : g_div
		always_ff @(posedge clk) begin
			lane_x_s[k+1] <= lane_step(lane_x_s[k], w_eff, 1'(k >= COORD_BITS));
			lane_y_s[k+1] <= lane_step(lane_y_s[k], h_eff, 1'(k >= COORD_BITS));
			ctl_s[k+1]    <= ctl_s[k];
		end
	end

	// table access: each corner of a cell falls in a different parity bank
	lane_t lx, ly;
	ctl_t  wc;
	logic  wr;
	logic [COORD_BITS:0]        cx1, cy1;
	logic [NUM_BANKS-1:0]       bank_we, bank_ok;
	logic [BANK_ADDR_BITS-1:0]  bank_waddr;
	logic [ENTRY_BITS-1:0]      bank_wdata;
	logic [BANK_ADDR_BITS-1:0]  bank_raddr [NUM_BANKS];
	logic [ENTRY_BITS-1:0]      bank_rdata [NUM_BANKS];

	assign lx  = lane_x_s[STAGES];
	assign ly  = lane_y_s[STAGES];
	assign wc  = ctl_s[STAGES];
	assign wr  = pipe_vld_s[STAGES] && (wc.op == OP_WRITE);
	assign cx1 = {1'b0, lx.quo} + 1'b1;
	assign cy1 = {1'b0, ly.quo} + 1'b1;

	assign bank_waddr = clr_q ? clr_addr_q : {wc.row[GRID_BITS-1:1], wc.col[GRID_BITS-1:1]};
	assign bank_wdata = clr_q ? '0 : {wc.gx, wc.gy};

	for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
		logic [COORD_BITS:0] col, row;
		always_comb begin
			col = (lx.quo[0] == b[0]) ? {1'b0, lx.quo} : cx1;
			row = (ly.quo[0] == b[1]) ? {1'b0, ly.quo} : cy1;
			bank_ok[b] = (col < (COORD_BITS+1)'(GRID_DIM)) && (row < (COORD_BITS+1)'(GRID_DIM));
			bank_raddr[b] = {row[GRID_BITS-1:1], col[GRID_BITS-1:1]};
			bank_we[b] = clr_q || (wr && ({wc.row[0], wc.col[0]} == 2'(b)));
		end

		pnpc_ram #(
			.WIDTH(ENTRY_BITS),
			.DEPTH(BANK_DEPTH)
		) u_bank (
			.clk  (clk),
			.we   (bank_we[b]),
			.waddr(bank_waddr),
			.wdata(bank_wdata),
			.raddr(bank_raddr[b]),
			.rdata(bank_rdata[b])
		);
	end

	// fade weights, computed alongside the table read
	logic [FADE_BITS-1:0] xw_s4, yw_s4, yw_s5, yw_s6, yw_s7;

	pnpc_fade u_fade_x (.clk(clk), .t(lx.frac), .fade(xw_s4));
	pnpc_fade u_fade_y (.clk(clk), .t(ly.frac), .fade(yw_s4));

	// pixel pipeline after the table read
	logic [POST:1] pix_vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_vld_s <= '0;
		end else begin
			pix_vld_s <= {pix_vld_s[POST-1:1],
				pipe_vld_s[STAGES] && (wc.op == OP_PIXEL)};
		end
	end

	logic [SIZE_BITS-1:0] ox_s1, oy_s1;
	logic [1:0]           par_s1;
	logic [NUM_BANKS-1:0] ok_s1;

	always_ff @(posedge clk) begin
		ox_s1  <= lx.off;
		oy_s1  <= ly.off;
		par_s1 <= {ly.quo[0], lx.quo[0]};
		ok_s1  <= bank_ok;
	end

	// dot products with corner offsets
	logic signed [PROD_W-1:0] pgx_s2 [NUM_BANKS];
	logic signed [PROD_W-1:0] pgy_s2 [NUM_BANKS];

	for (genvar c = 0; c < NUM_BANKS; c++) begin : g_corner
		logic [1:0]                  bk;
		logic signed [GRAD_BITS-1:0] gx, gy;
		logic signed [SIZE_BITS:0]   dx, dy;
		always_comb begin
			bk = par_s1 ^ 2'(c);
			gx = ok_s1[bk] ? bank_rdata[bk][ENTRY_BITS-1:GRAD_BITS] : '0;
			gy = ok_s1[bk] ? bank_rdata[bk][GRAD_BITS-1:0] : '0;
			dx = $signed({1'b0, ox_s1}) - ((c % 2 == 1) ? $signed({1'b0, w_eff}) : '0);
			dy = $signed({1'b0, oy_s1}) - ((c / 2 == 1) ? $signed({1'b0, h_eff}) : '0);
		end
		always_ff @(posedge clk) begin
			pgx_s2[c] <= gx * dx;
			pgy_s2[c] <= gy * dy;
		end
	end

	logic signed [VAL_W-1:0]  val_s3 [NUM_BANKS];
	logic signed [DIF_W-1:0]  dif_s4 [2];
	logic signed [DIF_W-1:0]  base_s4 [2], base_s5 [2];
	logic signed [MUL_W-1:0]  mul_s5 [2];
	logic signed [AB_W-1:0]   ab_s6 [2];
	logic signed [DB_W-1:0]   db_s7, a_s7, a_s8, blend_s9;
	logic signed [MUL2_W-1:0] mul2_s8;

	always_ff @(posedge clk) begin
		for (int c = 0; c < NUM_BANKS; c++) begin
			val_s3[c] <= VAL_W'(pgx_s2[c]) + VAL_W'(pgy_s2[c]);
		end
		for (int k = 0; k < 2; k++) begin
			dif_s4[k]  <= DIF_W'(val_s3[2*k+1]) - DIF_W'(val_s3[2*k]);
			base_s4[k] <= DIF_W'(val_s3[2*k]);
			mul_s5[k]  <= $signed({1'b0, xw_s4}) * dif_s4[k];
			base_s5[k] <= base_s4[k];
			ab_s6[k]   <= AB_W'(base_s5[k]) + AB_W'(mul_s5[k] >>> T_BITS);
		end
		yw_s5    <= yw_s4;
		yw_s6    <= yw_s5;
		yw_s7    <= yw_s6;
		db_s7    <= DB_W'(ab_s6[1]) - DB_W'(ab_s6[0]);
		a_s7     <= DB_W'(ab_s6[0]);
		mul2_s8  <= $signed({1'b0, yw_s7}) * db_s7;
		a_s8     <= a_s7;
		blend_s9 <= a_s8 + DB_W'(mul2_s8 >>> T_BITS);
	end

	// scale to Q12.8 and saturate
	localparam logic signed [DB_W-1:0] NMAX = DB_W'((1 << (NOISE_BITS - 1)) - 1);
	localparam logic signed [DB_W-1:0] NMIN = -DB_W'(1 << (NOISE_BITS - 1));

	logic signed [DB_W-1:0]       nsh;
	logic signed [NOISE_BITS-1:0] noise_s10, noise_s11;

	assign nsh = blend_s9 >>> (GRAD_FRAC_BITS - 8);

	always_ff @(posedge clk) begin
		priority if (nsh > NMAX) begin
			noise_s10 <= NMAX[NOISE_BITS-1:0];
		end else if (nsh < NMIN) begin
			noise_s10 <= NMIN[NOISE_BITS-1:0];
		end else begin
			noise_s10 <= nsh[NOISE_BITS-1:0];
		end
	end

	// colour value, truncated toward zero, and its magnitude over six
	logic signed [NOISE_BITS:0] nrnd;
	logic signed [V_W-1:0]      v, v_s11;
	logic [ABS_W-1:0]           absv, abs_s11;
	logic [RP_W-1:0]            rprod;
	logic [Q6_W-1:0]            q6_s11;

	always_comb begin
		nrnd  = (noise_s10 < 0) ? ((NOISE_BITS+1)'(noise_s10) + (NOISE_BITS+1)'(255))
			: (NOISE_BITS+1)'(noise_s10);
		v     = V_W'(nrnd >>> 8) + V_W'(VALUE_OFFSET);
		absv  = (v < 0) ? ABS_W'(-v) : ABS_W'(v);
		rprod = RP_W'(absv) * RP_W'(RECIP6);
	end

	always_ff @(posedge clk) begin
		noise_s11 <= noise_s10;
		v_s11     <= v;
		abs_s11   <= absv;
		q6_s11    <= rprod[RECIP_SHIFT +: Q6_W];
	end

	logic [2:0]             rem6;
	logic [COLOUR_BITS-1:0] ramp;
	logic [COLOUR_BITS-1:0] r_d, g_d, b_d;

	always_comb begin
		rem6 = 3'(abs_s11 - ABS_W'(q6_s11 * ABS_W'(STRIPE_PERIOD)));
		ramp = COLOUR_BITS'(v_s11) * COLOUR_BITS'(RAMP_SCALE);
		r_d  = '0;
		g_d  = '0;
		b_d  = '0;
		unique case (colour_mode_q)
			MODE_RAMP: begin
				r_d = ramp;
				b_d = COLOUR_BITS'(0) - ramp;
			end
			MODE_STRIPES: begin
				// only positive values take the even non-zero remainder stripes
				priority if (rem6 == 3'(STRIPE_A)) begin
					r_d = COLOUR_BITS'(COL_100);
					b_d = COLOUR_BITS'(COL_150);
				end else if (v_s11 > 0 && rem6 == 3'(STRIPE_B)) begin
					g_d = COLOUR_BITS'(COL_200);
					b_d = COLOUR_BITS'(COL_20);
				end else if (v_s11 > 0 && rem6 == 3'(STRIPE_C)) begin
					r_d = COLOUR_BITS'(COL_200);
					b_d = COLOUR_BITS'(COL_20);
				end else begin
					r_d = COLOUR_BITS'(COL_250);
					g_d = COLOUR_BITS'(COL_250);
					b_d = COLOUR_BITS'(COL_250);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= pix_vld_s[POST];
		end
	end

	always_ff @(posedge clk) begin
		noise_value <= noise_s11;
		red         <= r_d;
		green       <= g_d;
		blue        <= b_d;
	end

	// checks
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result while table still clearing");

	assert property (@(posedge clk) disable iff (!arst_n) !clr_q |-> $onehot0(bank_we))
		else $error("gradient write hit more than one bank");

	assert property (@(posedge clk) disable iff (!arst_n) clr_q |-> (bank_we == '1))
		else $error("bank skipped during clear");

	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> ($past(clr_addr_q) == '1))
		else $error("clear ended before last row");

endmodule
